### src/imuma_pkg.sv
// Shared constants, types and reciprocal table of the IMU offset and moving-average block.
`default_nettype none

package imuma_pkg;

   // Window geometry
   localparam int WINDOW_DEPTH = 20;
   localparam int AXES         = 3;

   // Field widths
   localparam int RAW_W       = 16;
   localparam int ACCEL_OFF_W = 17;
   localparam int GYRO_OFF_W  = 16;
   localparam int ACCEL_W     = 18;
   localparam int GYRO_W      = 17;
   localparam int MEAN_W      = 21;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   // Derived sizes of the window state
   localparam int SLOT_W = (WINDOW_DEPTH > 2) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W  = GYRO_W + $clog2(WINDOW_DEPTH);
   localparam int NUM_W  = SUM_W + 4;
   localparam int MEM_W  = AXES * GYRO_W;
   localparam int SQ_W   = 2 * ACCEL_W;

   // Sanity window on squared magnitude, (0.5 g)^2 and (1.5 g)^2 at 16384 counts/g
   localparam logic [SQ_W-1:0] MAG_LO = SQ_W'(longint'(8192) * 8192);
   localparam logic [SQ_W-1:0] MAG_HI = SQ_W'(longint'(24576) * 24576);

   // Reciprocal table floor(2^RECIP_SHIFT / d), d = 1..64; the shift covers
   // numerators up to 27 bits, enough for any window depth up to 64
   localparam int     RECIP_SHIFT = 27;
   localparam int     RECIP_W     = RECIP_SHIFT + 1;
   localparam int     RECIP_DEPTH = 64;
   localparam int     RECIP_IDX_W = 6;
   localparam longint RECIP_NUM   = longint'(1) << RECIP_SHIFT;

   localparam logic [RECIP_W-1:0] RECIP_TABLE [RECIP_DEPTH] = '{
      RECIP_W'(RECIP_NUM / 1),  RECIP_W'(RECIP_NUM / 2),
      RECIP_W'(RECIP_NUM / 3),  RECIP_W'(RECIP_NUM / 4),
      RECIP_W'(RECIP_NUM / 5),  RECIP_W'(RECIP_NUM / 6),
      RECIP_W'(RECIP_NUM / 7),  RECIP_W'(RECIP_NUM / 8),
      RECIP_W'(RECIP_NUM / 9),  RECIP_W'(RECIP_NUM / 10),
      RECIP_W'(RECIP_NUM / 11), RECIP_W'(RECIP_NUM / 12),
      RECIP_W'(RECIP_NUM / 13), RECIP_W'(RECIP_NUM / 14),
      RECIP_W'(RECIP_NUM / 15), RECIP_W'(RECIP_NUM / 16),
      RECIP_W'(RECIP_NUM / 17), RECIP_W'(RECIP_NUM / 18),
      RECIP_W'(RECIP_NUM / 19), RECIP_W'(RECIP_NUM / 20),
      RECIP_W'(RECIP_NUM / 21), RECIP_W'(RECIP_NUM / 22),
      RECIP_W'(RECIP_NUM / 23), RECIP_W'(RECIP_NUM / 24),
      RECIP_W'(RECIP_NUM / 25), RECIP_W'(RECIP_NUM / 26),
      RECIP_W'(RECIP_NUM / 27), RECIP_W'(RECIP_NUM / 28),
      RECIP_W'(RECIP_NUM / 29), RECIP_W'(RECIP_NUM / 30),
      RECIP_W'(RECIP_NUM / 31), RECIP_W'(RECIP_NUM / 32),
      RECIP_W'(RECIP_NUM / 33), RECIP_W'(RECIP_NUM / 34),
      RECIP_W'(RECIP_NUM / 35), RECIP_W'(RECIP_NUM / 36),
      RECIP_W'(RECIP_NUM / 37), RECIP_W'(RECIP_NUM / 38),
      RECIP_W'(RECIP_NUM / 39), RECIP_W'(RECIP_NUM / 40),
      RECIP_W'(RECIP_NUM / 41), RECIP_W'(RECIP_NUM / 42),
      RECIP_W'(RECIP_NUM / 43), RECIP_W'(RECIP_NUM / 44),
      RECIP_W'(RECIP_NUM / 45), RECIP_W'(RECIP_NUM / 46),
      RECIP_W'(RECIP_NUM / 47), RECIP_W'(RECIP_NUM / 48),
      RECIP_W'(RECIP_NUM / 49), RECIP_W'(RECIP_NUM / 50),
      RECIP_W'(RECIP_NUM / 51), RECIP_W'(RECIP_NUM / 52),
      RECIP_W'(RECIP_NUM / 53), RECIP_W'(RECIP_NUM / 54),
      RECIP_W'(RECIP_NUM / 55), RECIP_W'(RECIP_NUM / 56),
      RECIP_W'(RECIP_NUM / 57), RECIP_W'(RECIP_NUM / 58),
      RECIP_W'(RECIP_NUM / 59), RECIP_W'(RECIP_NUM / 60),
      RECIP_W'(RECIP_NUM / 61), RECIP_W'(RECIP_NUM / 62),
      RECIP_W'(RECIP_NUM / 63), RECIP_W'(RECIP_NUM / 64)
   };

   // Gyro axis tag
   typedef logic [1:0] axis_type;
   localparam axis_type AXIS_LAST = axis_type'(AXES - 1);

   // Control beat into and out of the mean divider
   typedef struct packed {
      logic     valid;
      axis_type axis;
   } div_ctl_type;

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ACCEL_X_OFFSET = 3'd0,
      REG_ACCEL_Y_OFFSET = 3'd1,
      REG_ACCEL_Z_OFFSET = 3'd2,
      REG_GYRO_X_OFFSET  = 3'd3,
      REG_GYRO_Y_OFFSET  = 3'd4,
      REG_GYRO_Z_OFFSET  = 3'd5
   } csr_reg_type;

endpackage

`default_nettype wire

### src/imu_offset_moving_average.sv
// Top level: IMU offset correction, gyro moving average and accelerometer sanity flag.
//
// One six-axis sample in, one result out. Each axis has its offset subtracted; the
// corrected accelerometer values pass through, and each gyro axis is averaged over a
// ring of the last WINDOW_DEPTH corrected values (mean over the filled entries, counts
// with 4 fraction bits, truncated toward zero). The accelerometer is flagged sane when
// its squared magnitude is strictly between (0.5 g)^2 and (1.5 g)^2. The ring lives in
// one single-port-style memory read at accept and written back in the following cycle. An
// item passes from accept through a ring update after the read, the issue of the three
// gyro sums one per cycle into the shared 4-stage mean divider until the last quotient
// returns, and the load of the result register. The next sample is taken only after
// that load, so a new sample is accepted only once the previous one has reached the
// result register. A new sample is taken while the previous result still waits on rsp;
// that sample then waits before its result load until the older result has left.
// Writing any gyro offset empties the window at once; memory contents are never swept,
// the fill state decides which entries count.
`default_nettype none

module imu_offset_moving_average (
   input  logic                                     clock,
   input  logic                                     reset,
   // configuration
   input  logic                                     csr_wen,
   input  logic        [imuma_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic        [imuma_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // sample channel
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [imuma_pkg::RAW_W-1:0]       req_accel_x_raw,
   input  logic signed [imuma_pkg::RAW_W-1:0]       req_accel_y_raw,
   input  logic signed [imuma_pkg::RAW_W-1:0]       req_accel_z_raw,
   input  logic signed [imuma_pkg::RAW_W-1:0]       req_gyro_x_raw,
   input  logic signed [imuma_pkg::RAW_W-1:0]       req_gyro_y_raw,
   input  logic signed [imuma_pkg::RAW_W-1:0]       req_gyro_z_raw,
   // result channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [imuma_pkg::ACCEL_W-1:0]     rsp_accel_x_out,
   output logic signed [imuma_pkg::ACCEL_W-1:0]     rsp_accel_y_out,
   output logic signed [imuma_pkg::ACCEL_W-1:0]     rsp_accel_z_out,
   output logic signed [imuma_pkg::MEAN_W-1:0]      rsp_gyro_x_mean,
   output logic signed [imuma_pkg::MEAN_W-1:0]      rsp_gyro_y_mean,
   output logic signed [imuma_pkg::MEAN_W-1:0]      rsp_gyro_z_mean,
   output logic                                     rsp_accel_sane
);
   import imuma_pkg::*;

   localparam int STEP_W = 3;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_UPD  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   // Offset registers
   logic signed [ACCEL_OFF_W-1:0] accel_off_ff [AXES];
   logic signed [GYRO_OFF_W-1:0]  gyro_off_ff  [AXES];
   logic                          gyro_clear;

   // Control state
   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              filled_ff, filled_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic signed [SUM_W-1:0] sum_ff [AXES];
   logic signed [SUM_W-1:0] sum_in [AXES];
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_load;
   logic              sq_vld_ff;

   // Item data
   logic signed [RAW_W-1:0]   accel_raw [AXES];
   logic signed [RAW_W-1:0]   gyro_raw  [AXES];
   logic signed [ACCEL_W-1:0] accel_ff  [AXES];
   logic signed [GYRO_W-1:0]  gyro_ff   [AXES];
   logic signed [GYRO_W-1:0]  old_val   [AXES];
   logic [MEM_W-1:0]          hist_mem  [WINDOW_DEPTH];
   logic [MEM_W-1:0]          rd_ff;
   logic signed [SQ_W-1:0]    sq_in;
   logic [SQ_W-1:0]           sq_ff;
   logic [SQ_W-1:0]           mag_ff;
   logic signed [MEAN_W-1:0]  mean_ff [AXES];

   // Divider hookup
   logic                   step_live;
   axis_type               axis_sel;
   div_ctl_type            div_issue;
   div_ctl_type            div_done;
   logic signed [MEAN_W-1:0] div_mean;

   // Result registers
   logic signed [ACCEL_W-1:0] rsp_accel_ff [AXES];
   logic signed [MEAN_W-1:0]  rsp_mean_ff  [AXES];
   logic                      rsp_sane_ff;

   logic accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      accel_raw[0] = req_accel_x_raw;
      accel_raw[1] = req_accel_y_raw;
      accel_raw[2] = req_accel_z_raw;
      gyro_raw[0]  = req_gyro_x_raw;
      gyro_raw[1]  = req_gyro_y_raw;
      gyro_raw[2]  = req_gyro_z_raw;
   end

   // Register write decode; any gyro offset write empties the window
   always_comb begin
      gyro_clear = 1'b0;
      if (csr_wen) begin
         case (csr_index) inside
            REG_GYRO_X_OFFSET, REG_GYRO_Y_OFFSET, REG_GYRO_Z_OFFSET: gyro_clear = 1'b1;
            default:                                                 gyro_clear = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            accel_off_ff[i] <= '0;
            gyro_off_ff[i]  <= '0;
         end
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_ACCEL_X_OFFSET: accel_off_ff[0] <= signed'(csr_wdata[ACCEL_OFF_W-1:0]);
            REG_ACCEL_Y_OFFSET: accel_off_ff[1] <= signed'(csr_wdata[ACCEL_OFF_W-1:0]);
            REG_ACCEL_Z_OFFSET: accel_off_ff[2] <= signed'(csr_wdata[ACCEL_OFF_W-1:0]);
            REG_GYRO_X_OFFSET:  gyro_off_ff[0]  <= signed'(csr_wdata[GYRO_OFF_W-1:0]);
            REG_GYRO_Y_OFFSET:  gyro_off_ff[1]  <= signed'(csr_wdata[GYRO_OFF_W-1:0]);
            REG_GYRO_Z_OFFSET:  gyro_off_ff[2]  <= signed'(csr_wdata[GYRO_OFF_W-1:0]);
            default: ;
         endcase
      end
   end

   // Ring entries not yet written since the last clear count as zero
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         old_val[i] = filled_ff ? signed'(rd_ff[i*GYRO_W +: GYRO_W]) : '0;
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      slot_in  = slot_ff;
      filled_in = filled_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_UPD;
         end
         ST_UPD: begin
            for (int i = 0; i < AXES; i++) begin
               sum_in[i] = sum_ff[i] + SUM_W'(gyro_ff[i]) - SUM_W'(old_val[i]);
            end
            if (slot_ff == SLOT_W'(WINDOW_DEPTH - 1)) begin
               slot_in   = '0;
               filled_in = 1'b1;
               count_in  = CNT_W'(WINDOW_DEPTH);
            end else begin
               slot_in  = slot_ff + SLOT_W'(1);
               count_in = filled_ff ? CNT_W'(WINDOW_DEPTH) : (CNT_W'(slot_ff) + CNT_W'(1));
            end
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            step_in = step_ff + STEP_W'(1);
            if (div_done.valid && (div_done.axis == AXIS_LAST)) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (gyro_clear) begin
         for (int i = 0; i < AXES; i++) sum_in[i] = '0;
         slot_in   = '0;
         filled_in = 1'b0;
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         slot_ff      <= '0;
         filled_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         sq_vld_ff    <= 1'b0;
         for (int i = 0; i < AXES; i++) sum_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         slot_ff      <= slot_in;
         filled_ff    <= filled_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         sq_vld_ff    <= (state_ff == ST_DIV) && step_live;
         sum_ff       <= sum_in;
      end
   end

   // Offset correction at accept
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < AXES; i++) begin
            accel_ff[i] <= ACCEL_W'(accel_raw[i]) - ACCEL_W'(accel_off_ff[i]);
            gyro_ff[i]  <= GYRO_W'(gyro_raw[i]) - GYRO_W'(gyro_off_ff[i]);
         end
      end
   end

   // History memory: read at the current slot, written back in the following cycle
   always_ff @(posedge clock) begin
      rd_ff <= hist_mem[slot_ff];
      if (state_ff == ST_UPD) begin
         hist_mem[slot_ff] <= {gyro_ff[2], gyro_ff[1], gyro_ff[0]};
      end
   end

   // One axis per cycle into the divider and the squarer
   assign step_live = (step_ff < STEP_W'(AXES));
   assign axis_sel  = step_live ? axis_type'(step_ff) : '0;
   assign sq_in     = accel_ff[axis_sel] * accel_ff[axis_sel];

   always_comb begin
      div_issue.valid = (state_ff == ST_DIV) && step_live;
      div_issue.axis  = axis_sel;
   end

   imuma_mean_div u_mean_div (
      .clock       (clock),
      .reset       (reset),
      .issue       (div_issue),
      .issue_sum   (sum_ff[axis_sel]),
      .issue_count (count_ff),
      .done        (div_done),
      .done_mean   (div_mean)
   );

   // Squared magnitude accumulate and mean capture
   always_ff @(posedge clock) begin
      sq_ff <= unsigned'(sq_in);
      if (state_ff == ST_UPD) begin
         mag_ff <= '0;
      end else if (sq_vld_ff) begin
         mag_ff <= mag_ff + sq_ff;
      end
      if (div_done.valid) begin
         case (div_done.axis)
            axis_type'(0): mean_ff[0] <= div_mean;
            axis_type'(1): mean_ff[1] <= div_mean;
            default:       mean_ff[2] <= div_mean;
         endcase
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_accel_ff <= accel_ff;
         rsp_mean_ff  <= mean_ff;
         rsp_sane_ff  <= (mag_ff > MAG_LO) && (mag_ff < MAG_HI);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accel_x_out = rsp_accel_ff[0];
   assign rsp_accel_y_out = rsp_accel_ff[1];
   assign rsp_accel_z_out = rsp_accel_ff[2];
   assign rsp_gyro_x_mean = rsp_mean_ff[0];
   assign rsp_gyro_y_mean = rsp_mean_ff[1];
   assign rsp_gyro_z_mean = rsp_mean_ff[2];
   assign rsp_accel_sane  = rsp_sane_ff;

   // Checks
   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done.valid |-> (state_ff == ST_DIV))
      else $error("divider result outside divide phase");

   a_accept_to_upd: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_UPD))
      else $error("accepted beat did not start the ring update");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> ((count_ff != '0) && (count_ff <= CNT_W'(WINDOW_DEPTH))))
      else $error("window count out of range during divide");

   a_gyro_clear: assert property (@(posedge clock) disable iff (reset)
      gyro_clear |=> ((slot_ff == '0) && !filled_ff))
      else $error("gyro offset write did not empty the window");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FIN))
      else $error("result raised outside the result load");

endmodule

`default_nettype wire

### src/imuma_mean_div.sv
// Pipelined signed divide of a window sum (times 16) by the fill count, via reciprocal.
`default_nettype none

module imuma_mean_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  imuma_pkg::div_ctl_type                issue,
   input  logic signed [imuma_pkg::SUM_W-1:0]    issue_sum,
   input  logic        [imuma_pkg::CNT_W-1:0]    issue_count,
   output imuma_pkg::div_ctl_type                done,
   output logic signed [imuma_pkg::MEAN_W-1:0]   done_mean
);
   import imuma_pkg::*;

   localparam int PROD_W = NUM_W + RECIP_W;
   localparam int FIX_W  = NUM_W + CNT_W;

   // Stage 1: magnitude, scale by 16, reciprocal lookup
   div_ctl_type            ctl1_ff, ctl2_ff, ctl3_ff, done_ff;
   logic                   neg1_ff, neg2_ff, neg3_ff;
   logic [NUM_W-1:0]       num1_ff, num2_ff, num3_ff;
   logic [CNT_W-1:0]       cnt1_ff, cnt2_ff, cnt3_ff;
   logic [RECIP_W-1:0]     rcp1_ff;
   logic [PROD_W-1:0]      prod2_ff;
   logic [NUM_W-1:0]       quo3_ff;
   logic signed [MEAN_W-1:0] mean_ff;

   logic                   neg_in;
   logic [SUM_W-1:0]       mag_in;
   logic [RECIP_IDX_W-1:0] rcp_idx;
   logic [FIX_W-1:0]       fix_prod;
   logic                   bump;
   logic [NUM_W-1:0]       quo_fix;
   logic [NUM_W-1:0]       quo_signed;

   always_comb begin
      neg_in  = issue_sum[SUM_W-1];
      mag_in  = neg_in ? SUM_W'(-issue_sum) : SUM_W'(issue_sum);
      rcp_idx = RECIP_IDX_W'(issue_count) - RECIP_IDX_W'(1);
   end

   // Stage 4: the reciprocal estimate is low by at most one
   always_comb begin
      fix_prod   = FIX_W'(quo3_ff) * FIX_W'(cnt3_ff);
      bump       = FIX_W'(num3_ff) >= (fix_prod + FIX_W'(cnt3_ff));
      quo_fix    = quo3_ff + NUM_W'(bump);
      quo_signed = neg3_ff ? (~quo_fix + NUM_W'(1)) : quo_fix;
   end

   // Control beats
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         done_ff <= '0;
      end else begin
         ctl1_ff <= issue;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         done_ff <= ctl3_ff;
      end
   end

   // Data path stages
   always_ff @(posedge clock) begin
      neg1_ff  <= neg_in;
      num1_ff  <= {mag_in, 4'b0000};
      cnt1_ff  <= issue_count;
      rcp1_ff  <= RECIP_TABLE[rcp_idx];

      neg2_ff  <= neg1_ff;
      num2_ff  <= num1_ff;
      cnt2_ff  <= cnt1_ff;
      prod2_ff <= PROD_W'(num1_ff) * PROD_W'(rcp1_ff);

      neg3_ff  <= neg2_ff;
      num3_ff  <= num2_ff;
      cnt3_ff  <= cnt2_ff;
      quo3_ff  <= prod2_ff[RECIP_SHIFT +: NUM_W];

      mean_ff  <= quo_signed[MEAN_W-1:0];
   end

   assign done      = done_ff;
   assign done_mean = mean_ff;

endmodule

`default_nettype wire
